[rtl/binary_range_encoder_macros.svh]
// ----------------------------------------------------------------------------
// binary_range_encoder_macros
// Assertion macros used by the checker file of the range encoder.
// ----------------------------------------------------------------------------
`ifndef BINARY_RANGE_ENCODER_MACROS_SVH
`define BINARY_RANGE_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BRE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bre_pkg.sv]
// ----------------------------------------------------------------------------
// bre_pkg
// Types and constants shared by the binary range encoder modules.
// ----------------------------------------------------------------------------
package bre_pkg;

  localparam int PROB_W  = 12;
  localparam int RANGE_W = 32;
  localparam int LOW_W   = 33;
  localparam int COUNT_W = 32;
  localparam int PROD_W  = RANGE_W + PROB_W;

  // func codes of an input transaction
  localparam logic FN_CODE  = 1'b0;
  localparam logic FN_FLUSH = 1'b1;

  // byte shifts made by a flush
  localparam logic [2:0] FLUSH_SHIFTS = 3'd5;

  localparam logic [7:0] BYTE_FF = 8'hff;

  typedef struct packed {
    logic              func;
    logic [PROB_W-1:0] prob;
    logic              bit_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic [COUNT_W-1:0] repeat_count;
    logic               last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;       // take a new item
    logic apply_bound;  // narrow the interval by the coded bit
    logic gen_cached;   // produce cached byte plus carry
    logic gen_run;      // produce the pending 0xff run
    logic clear_first;  // drop the very first cached byte
    logic shift_step;   // finish one byte shift
    logic finish;       // close the item, mark its last result
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;         // another byte shift is due
    logic take;         // low settles a byte (no pending 0xff)
    logic first;        // first cached byte still to be dropped
    logic pending_nz;   // a run of 0xff bytes is pending
    logic stall;        // held result cannot move to the output yet
  } ctl_sts_t;

endpackage

[rtl/bre_ctrl.sv]
// ----------------------------------------------------------------------------
// bre_ctrl
// Sequencer of the range encoder: bound, renormalizing shifts, result release.
// ----------------------------------------------------------------------------
module bre_ctrl import bre_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  input  logic     func,
  output logic     cmd_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_BOUND  = 5'b00010,
    S_NORM   = 5'b00100,
    S_EMIT_C = 5'b01000,
    S_EMIT_F = 5'b10000
  } state_t;

  state_t state, state_next;

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.accept = 1'b1;
          state_next = (func == FN_FLUSH) ? S_NORM : S_BOUND;
        end
      end
      S_BOUND: begin
        ctl.apply_bound = 1'b1;
        state_next      = S_NORM;
      end
      S_NORM: begin
        if (sts.more) begin
          if (sts.take) begin
            state_next = S_EMIT_C;
          end else begin
            ctl.shift_step = 1'b1;
          end
        end else if (!sts.stall) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMIT_C: begin
        if (sts.first) begin
          ctl.clear_first = 1'b1;
          state_next      = S_EMIT_F;
        end else if (!sts.stall) begin
          ctl.gen_cached = 1'b1;
          state_next     = S_EMIT_F;
        end
      end
      S_EMIT_F: begin
        if (!sts.pending_nz) begin
          ctl.shift_step = 1'b1;
          state_next     = S_NORM;
        end else if (!sts.stall) begin
          ctl.gen_run    = 1'b1;
          ctl.shift_step = 1'b1;
          state_next     = S_NORM;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/bre_datapath.sv]
// ----------------------------------------------------------------------------
// bre_datapath
// Coder state, bound multiplier, byte shifter, hold stage and output register.
// ----------------------------------------------------------------------------
module bre_datapath import bre_pkg::*; #(
  parameter int PROB_BITS      = 12,
  parameter int RUN_COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  cmd,
  input  ctl_cmd_t  ctl,
  output ctl_sts_t  sts,
  input  logic      rsp_ready,
  output logic      rsp_valid,
  output out_item_t rsp
);

  localparam int unsigned ProbMax = (32'd1 << PROB_BITS) - 32'd1;
  localparam logic [RUN_COUNT_BITS-1:0] PendMax = '1;

  logic [LOW_W-1:0]          low;
  logic [RANGE_W-1:0]        range_q;
  logic [7:0]                cached;
  logic [RUN_COUNT_BITS-1:0] pending;
  logic                      first;
  logic                      flush_mode;
  logic [2:0]                shifts_left;

  logic                      bit_q;
  logic [PROD_W-1:0]         prod;
  logic [PROB_W-1:0]         prob_eff;
  logic [PROD_W-1:0]         bound_wide;
  logic [RANGE_W-1:0]        bound;

  logic                      hold_valid;
  logic [7:0]                hold_byte;
  logic [COUNT_W-1:0]        hold_count;

  logic                      carry;
  logic                      take;
  logic                      out_free;
  logic                      gen;
  logic [7:0]                gen_byte;
  logic [COUNT_W-1:0]        gen_count;
  logic                      push;

  // zero probability acts as one, large ones are capped below the full scale
  always_comb begin
    prob_eff = (cmd.prob == '0) ? PROB_W'(1) : cmd.prob;
    if (32'(prob_eff) > ProbMax) begin
      prob_eff = PROB_W'(ProbMax);
    end
  end

  assign bound_wide = prod >> PROB_BITS;
  assign bound      = bound_wide[RANGE_W-1:0];

  assign carry    = low[LOW_W-1];
  assign take     = carry | (low[31:24] != BYTE_FF);
  assign out_free = !rsp_valid || rsp_ready;

  assign gen       = ctl.gen_cached | ctl.gen_run;
  assign gen_byte  = ctl.gen_cached ? (cached + {7'd0, carry})
                                    : (carry ? 8'h00 : BYTE_FF);
  assign gen_count = ctl.gen_cached ? COUNT_W'(1) : COUNT_W'(pending);

  // the held result moves out when a newer one arrives or the item closes
  assign push = hold_valid && (gen || ctl.finish);

  always_comb begin
    sts.more       = flush_mode ? (shifts_left != '0) : (range_q[31:24] == 8'h00);
    sts.take       = take;
    sts.first      = first;
    sts.pending_nz = (pending != '0);
    sts.stall      = hold_valid && !out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low         <= '0;
      range_q     <= '1;
      cached      <= '0;
      pending     <= '0;
      first       <= 1'b1;
      flush_mode  <= 1'b0;
      shifts_left <= '0;
      hold_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (ctl.accept) begin
        flush_mode  <= (cmd.func == FN_FLUSH);
        shifts_left <= FLUSH_SHIFTS;
      end
      if (ctl.apply_bound) begin
        if (bit_q) begin
          range_q <= bound;
        end else begin
          low     <= low + {1'b0, bound};
          range_q <= range_q - bound;
        end
      end
      if (ctl.clear_first) begin
        first <= 1'b0;
      end
      if (ctl.shift_step) begin
        if (take) begin
          cached  <= low[31:24];
          pending <= '0;
        end else if (pending != PendMax) begin
          pending <= pending + 1'b1;
        end
        low     <= {1'b0, low[23:0], 8'h00};
        range_q <= {range_q[23:0], 8'h00};
        if (shifts_left != '0) begin
          shifts_left <= shifts_left - 1'b1;
        end
      end
      if (gen) begin
        hold_valid <= 1'b1;
      end else if (ctl.finish) begin
        hold_valid <= 1'b0;
      end
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      // a flush leaves the coder as after reset
      if (ctl.finish && flush_mode) begin
        low        <= '0;
        range_q    <= '1;
        cached     <= '0;
        pending    <= '0;
        first      <= 1'b1;
        flush_mode <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      bit_q <= cmd.bit_req;
      prod  <= PROD_W'(range_q) * PROD_W'(prob_eff);
    end
    if (gen) begin
      hold_byte  <= gen_byte;
      hold_count <= gen_count;
    end
    if (push) begin
      rsp.out_byte     <= hold_byte;
      rsp.repeat_count <= hold_count;
      rsp.last         <= ctl.finish;
    end
  end

endmodule

[rtl/binary_range_encoder.sv]
// ----------------------------------------------------------------------------
// binary_range_encoder
// Binary range encoder with cached-byte carry handling and 0xff run counts.
// ----------------------------------------------------------------------------
// One transaction at a time on cmd: cmd_ready is high only between items. A
// coded bit is accepted, then bounded, then renormalized; a byte shift that
// only extends the pending 0xff run is a lone shift step, while one that
// settles a byte first releases the cached byte and any pending 0xff run; a
// bit makes at most two shifts, a flush skips the bound and makes five. The bound
// multiply is registered once in the acceptance cycle; the rest is paced by
// the sequencer stepping one byte shift at a time. Each result waits in a
// hold stage until the next one or the end of its item is known, so that
// last can be set, and then passes to the output register; a slow rsp side
// only stalls the sequencer when both are full.
module binary_range_encoder import bre_pkg::*; #(
  parameter int PROB_BITS      = 12,
  parameter int RUN_COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  in_item_t  cmd,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  bre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .func      (cmd.func),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  bre_datapath #(
    .PROB_BITS      (PROB_BITS),
    .RUN_COUNT_BITS (RUN_COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

[rtl/bre_checker.sv]
// ----------------------------------------------------------------------------
// bre_checker
// Port-level checks of the range encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_range_encoder_macros.svh"

module bre_checker import bre_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input in_item_t  cmd,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input out_item_t rsp
);

  logic cmd_take;
  logic cmd_wait;
  logic rsp_stall;
  logic rsp_run;
  logic run_byte;

  assign cmd_take  = cmd_valid && cmd_ready;
  assign cmd_wait  = cmd_valid && !cmd_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_run   = rsp_valid && (rsp.repeat_count != COUNT_W'(1));
  assign run_byte  = (rsp.out_byte == BYTE_FF) || (rsp.out_byte == 8'h00);

  // a waiting transaction holds still
  `BRE_ASSERT_NEXT(a_cmd_hold, cmd_wait, cmd_valid && $stable(cmd), "cmd changed while waiting")

  // a stalled result holds still
  `BRE_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")

  // items are worked one at a time
  `BRE_ASSERT_NEXT(a_one_item, cmd_take, !cmd_ready, "cmd taken on back-to-back cycles")

  `BRE_ASSERT_IMPLY(a_count_nz, rsp_valid, rsp.repeat_count != '0, "zero repeat count")

  // only a carried or uncarried 0xff run repeats
  `BRE_ASSERT_IMPLY(a_run_byte, rsp_run, run_byte, "repeated byte is not a run byte")

endmodule

bind binary_range_encoder bre_checker u_bre_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

[bench/binary_range_encoder_test.sv]
// ----------------------------------------------------------------------------
// binary_range_encoder_test
// Self-checking bench for the binary range encoder. Coded bits and flushes go
// in over cmd, and a bit-accurate coder model in the bench predicts every
// byte and run that should leave on rsp. Directed corner cases come first,
// then random bit streams mostly closed by flushes, under three idling profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_range_encoder_test;
  import bre_pkg::*;

  localparam logic [RANGE_W-1:0] RENORM_LIMIT = 32'h0100_0000;
  localparam logic [LOW_W-1:0]   HIGH_MARK    = 33'h0_ff00_0000;
  localparam logic [PROB_W-1:0]  PROB_TOP     = '1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  in_item_t  cmd = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_item_t rsp;

  // coder model state
  logic [LOW_W-1:0]   low_reg;
  logic [RANGE_W-1:0] range_reg;
  logic [7:0]         cache_byte;
  logic [COUNT_W-1:0] ff_run;
  logic               first_pending;

  out_item_t byte_q[$];    // bytes still owed by the encoder, oldest first
  out_item_t item_bytes[$];

  int send_idle;
  int recv_idle;
  int errors = 0;

  binary_range_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (byte_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual %p", $time, rsp);
      end else begin
        want = byte_q.pop_front();
        if (rsp.out_byte !== want.out_byte) begin
          errors++;
          $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                   rsp.out_byte);
        end
        if (rsp.repeat_count !== want.repeat_count) begin
          errors++;
          $display("%0t: repeat_count expected %0d actual %0d", $time,
                   want.repeat_count, rsp.repeat_count);
        end
        if (rsp.last !== want.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, want.last, rsp.last);
        end
      end
    end
  end

  function automatic void coder_clear();
    low_reg       = '0;
    range_reg     = '1;
    cache_byte    = '0;
    ff_run        = '0;
    first_pending = 1'b1;
  endfunction

  function automatic void emit_byte(logic [7:0] value, logic [COUNT_W-1:0] count);
    out_item_t r;
    r.out_byte     = value;
    r.repeat_count = count;
    r.last         = 1'b0;
    item_bytes.push_back(r);
  endfunction

  function automatic void shift_out_byte();
    logic carry;
    carry = low_reg[LOW_W-1];
    if (low_reg < HIGH_MARK || carry) begin
      if (!first_pending) begin
        emit_byte(cache_byte + 8'(carry), 1);
      end else begin
        first_pending = 1'b0;
      end
      if (ff_run != 0) begin
        emit_byte(BYTE_FF + 8'(carry), ff_run);
        ff_run = '0;
      end
      cache_byte = low_reg[31:24];
    end else if (ff_run != '1) begin
      ff_run++;
    end
    low_reg = {1'b0, low_reg[23:0], 8'h00};
  endfunction

  function automatic void encode_item(in_item_t it);
    logic [PROB_W-1:0]  p;
    logic [PROD_W-1:0]  prod;
    logic [RANGE_W-1:0] bound;
    item_bytes.delete();
    if (it.func == FN_FLUSH) begin
      for (int i = 0; i < int'(FLUSH_SHIFTS); i++) begin
        shift_out_byte();
      end
      coder_clear();
    end else begin
      p = (it.prob == 0) ? PROB_W'(1) : it.prob;
      prod = PROD_W'(range_reg) * PROD_W'(p);
      bound = prod[PROD_W-1:PROB_W];
      if (it.bit_req) begin
        range_reg = bound;
      end else begin
        low_reg   = low_reg + LOW_W'(bound);
        range_reg = range_reg - bound;
      end
      while (range_reg < RENORM_LIMIT) begin
        range_reg = range_reg << 8;
        shift_out_byte();
      end
    end
    if (item_bytes.size() > 0) begin
      item_bytes[item_bytes.size()-1].last = 1'b1;
    end
    foreach (item_bytes[i]) begin
      byte_q.push_back(item_bytes[i]);
    end
  endfunction

  task automatic send_item(input logic fn, input logic [PROB_W-1:0] p, input logic b);
    in_item_t it;
    it.func    = fn;
    it.prob    = p;
    it.bit_req = b;
    while ($urandom_range(99) < send_idle) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= it;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    encode_item(it);
  endtask

  task automatic settle();
    int cycles;
    cycles = 0;
    cmd_valid <= 1'b0;
    while (byte_q.size() != 0 && cycles < 20000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [PROB_W-1:0] pick_prob();
    case ($urandom_range(9))
      0:       return '0;
      1:       return PROB_TOP;
      2:       return PROB_W'($urandom_range(15));
      3, 4:    return PROB_W'($urandom_range(4095, 3968));
      default: return PROB_W'($urandom_range(4095));
    endcase
  endfunction

  task automatic test_directed();
    send_item(FN_CODE, 12'h800, 1'b1);
    // zero probability counts as one
    send_item(FN_CODE, 12'h000, 1'b0);
    send_item(FN_CODE, 12'h000, 1'b1);
    send_item(FN_CODE, PROB_TOP, 1'b1);
    // unlikely zeros push low high: 0xff runs and carries
    send_item(FN_CODE, PROB_TOP, 1'b0);
    send_item(FN_CODE, PROB_TOP, 1'b0);
    send_item(FN_CODE, PROB_TOP, 1'b0);
    send_item(FN_CODE, 12'h001, 1'b1);
    send_item(FN_FLUSH, 12'h000, 1'b0);
    // flush of a coder left as after reset, fields ignored
    send_item(FN_FLUSH, PROB_TOP, 1'b1);
    send_item(FN_CODE, PROB_TOP, 1'b0);
    send_item(FN_CODE, 12'hffe, 1'b0);
    send_item(FN_CODE, 12'h001, 1'b0);
    send_item(FN_CODE, PROB_TOP, 1'b0);
    send_item(FN_CODE, 12'h555, 1'b0);
    send_item(FN_CODE, 12'haaa, 1'b1);
    send_item(FN_CODE, 12'h800, 1'b0);
    send_item(FN_CODE, 12'h000, 1'b1);
    send_item(FN_FLUSH, 12'h555, 1'b0);
    settle();
  endtask

  // bit streams of random length, mostly closed by a flush
  task automatic test_random_coding(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(24, 1);
      for (int i = 0; i < len && sent < n; i++) begin
        if ($urandom_range(15) == 0) begin
          send_item(FN_FLUSH, PROB_W'($urandom), 1'($urandom));
        end else begin
          send_item(FN_CODE, pick_prob(), 1'($urandom));
        end
        sent++;
      end
      if ($urandom_range(9) != 0) begin
        send_item(FN_FLUSH, PROB_W'($urandom), 1'($urandom));
        sent++;
      end
    end
    settle();
  endtask

  initial begin
    send_idle = 13;
    recv_idle = 56;
    coder_clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_coding(80);
    send_idle = 56;
    recv_idle = 13;
    test_random_coding(80);
    send_idle = 0;
    recv_idle = 0;
    test_random_coding(100);
    if (errors == 0 && byte_q.size() == 0) begin
      $display("binary_range_encoder_test: PASS");
    end else begin
      if (byte_q.size() != 0) begin
        $display("%0t: %0d expected transactions never arrived, next %p", $time,
                 byte_q.size(), byte_q[0]);
      end
      $display("binary_range_encoder_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("binary_range_encoder_test: FAIL");
    $finish;
  end

endmodule
